@@ sv/htt_pkg.sv @@
// ----------------------------------------------------------------------------
// htt_pkg
// Shared types and constants for the HTML tag head tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package htt_pkg;

    // Width of the saturating consumed-byte counter (8 to 32)
    localparam int LENGTH_BITS = 16;
    localparam int TAG_LEN_W   = 16;
    localparam int BYTE_W      = 8;

    localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LT  = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GT  = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_EQ  = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_DQ  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SQ  = 8'h27;
    localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_PRE      = 4'd1,
        PH_TAGNAME  = 4'd2,
        PH_GAP      = 4'd3,
        PH_ANAME    = 4'd4,
        PH_AFTNAME  = 4'd5,
        PH_AFTEQ    = 4'd6,
        PH_QUOTED   = 4'd7,
        PH_UNQUOTED = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        ROLE_SYNTAX = 3'd0,
        ROLE_TAG    = 3'd1,
        ROLE_ANAME  = 3'd2,
        ROLE_VALUE  = 3'd3,
        ROLE_QUOTE  = 3'd4
    } role_t;

    typedef enum logic [1:0] {
        QK_NONE   = 2'd0,
        QK_DOUBLE = 2'd1,
        QK_SINGLE = 2'd2
    } qkind_t;

    typedef enum logic [2:0] {
        OC_BUSY     = 3'd0,
        OC_GT       = 3'd1,
        OC_NUL      = 3'd2,
        OC_STRAY_EQ = 3'd3,
        OC_NOT_TAG  = 3'd4
    } outc_t;

    typedef struct packed {
        role_t                role;
        logic                 taken;
        logic                 done;
        qkind_t               qk;
        outc_t                outc;
        logic [TAG_LEN_W-1:0] tag_length;
    } result_t;

endpackage

`default_nettype wire

@@ sv/htt_in_reg.sv @@
// ----------------------------------------------------------------------------
// htt_in_reg
// Input register: captures one byte per item, holds it until the step
// logic consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module htt_in_reg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [htt_pkg::BYTE_W-1:0]     data_byte,
    input  wire logic                           advance,
    output logic                                held_valid,
    output logic [htt_pkg::BYTE_W-1:0]          held_byte
);

    logic                         valid_reg;
    logic                         valid_next;
    logic [htt_pkg::BYTE_W-1:0]   byte_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= data_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

`default_nettype wire

@@ sv/htt_fsm.sv @@
// ----------------------------------------------------------------------------
// htt_fsm
// Parse state and per-byte step logic: classifies the held byte, walks the
// phase chain combinationally and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module htt_fsm (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           advance,
    input  wire logic [htt_pkg::BYTE_W-1:0]     cur_byte,
    output htt_pkg::result_t                    res
);

    htt_pkg::phase_t                     phase_reg;
    htt_pkg::phase_t                     phase_next;
    logic                                qsingle_reg;
    logic                                qsingle_next;
    logic [htt_pkg::LENGTH_BITS-1:0]     count_reg;
    logic [htt_pkg::LENGTH_BITS-1:0]     count_next;
    logic [htt_pkg::LENGTH_BITS-1:0]     count_base;

    logic is_sp, is_gt, is_eq, is_nul, is_lt, is_dq, is_sq, q_match;
    logic clear_cnt;
    logic [31:0] count_ext;

    assign is_sp  = (cur_byte == htt_pkg::CH_SP) ||
                    ((cur_byte >= htt_pkg::CH_TAB) && (cur_byte <= htt_pkg::CH_CR));
    assign is_gt  = (cur_byte == htt_pkg::CH_GT);
    assign is_eq  = (cur_byte == htt_pkg::CH_EQ);
    assign is_nul = (cur_byte == htt_pkg::CH_NUL);
    assign is_lt  = (cur_byte == htt_pkg::CH_LT);
    assign is_dq  = (cur_byte == htt_pkg::CH_DQ);
    assign is_sq  = (cur_byte == htt_pkg::CH_SQ);
    assign q_match = qsingle_reg ? is_sq : is_dq;

    always_comb
    begin
        res.role       = htt_pkg::ROLE_SYNTAX;
        res.taken      = 1'b0;
        res.done       = 1'b0;
        res.qk         = htt_pkg::QK_NONE;
        res.outc       = htt_pkg::OC_BUSY;
        res.tag_length = '0;
        phase_next     = phase_reg;
        qsingle_next   = qsingle_reg;
        clear_cnt      = 1'b0;

        // Phases that hand the byte on fall through to the gap handling
        case (phase_reg)
            htt_pkg::PH_PRE, htt_pkg::PH_TAGNAME:
            begin
                if (phase_reg == htt_pkg::PH_PRE && is_sp)
                begin
                    res.taken = 1'b1;
                end
                else if (!is_sp && !is_gt && !is_nul)
                begin
                    res.role   = htt_pkg::ROLE_TAG;
                    res.taken  = 1'b1;
                    phase_next = htt_pkg::PH_TAGNAME;
                end
                else
                begin
                    phase_next = htt_pkg::PH_GAP;
                end
            end
            htt_pkg::PH_GAP:
            begin
                phase_next = htt_pkg::PH_GAP;
            end
            htt_pkg::PH_ANAME, htt_pkg::PH_AFTNAME:
            begin
                if (phase_reg == htt_pkg::PH_ANAME && !is_sp && !is_eq && !is_gt && !is_nul)
                begin
                    res.role  = htt_pkg::ROLE_ANAME;
                    res.taken = 1'b1;
                end
                else if (is_sp)
                begin
                    res.taken  = 1'b1;
                    phase_next = htt_pkg::PH_AFTNAME;
                end
                else if (is_eq)
                begin
                    res.taken  = 1'b1;
                    phase_next = htt_pkg::PH_AFTEQ;
                end
                else
                begin
                    res.done   = 1'b1;
                    phase_next = htt_pkg::PH_GAP;
                end
            end
            htt_pkg::PH_AFTEQ, htt_pkg::PH_UNQUOTED:
            begin
                if (phase_reg == htt_pkg::PH_AFTEQ && is_sp)
                begin
                    res.taken = 1'b1;
                end
                else if (phase_reg == htt_pkg::PH_AFTEQ && (is_dq || is_sq))
                begin
                    res.taken    = 1'b1;
                    res.role     = htt_pkg::ROLE_QUOTE;
                    qsingle_next = is_sq;
                    phase_next   = htt_pkg::PH_QUOTED;
                end
                else if (!is_sp && !is_gt && !is_nul)
                begin
                    res.role   = htt_pkg::ROLE_VALUE;
                    res.taken  = 1'b1;
                    phase_next = htt_pkg::PH_UNQUOTED;
                end
                else
                begin
                    res.done   = 1'b1;
                    phase_next = htt_pkg::PH_GAP;
                end
            end
            htt_pkg::PH_QUOTED:
            begin
                if (q_match)
                begin
                    res.taken  = 1'b1;
                    res.role   = htt_pkg::ROLE_QUOTE;
                    res.done   = 1'b1;
                    res.qk     = qsingle_reg ? htt_pkg::QK_SINGLE : htt_pkg::QK_DOUBLE;
                    phase_next = htt_pkg::PH_GAP;
                end
                else if (is_nul)
                begin
                    res.done = 1'b1;
                    res.qk   = qsingle_reg ? htt_pkg::QK_SINGLE : htt_pkg::QK_DOUBLE;
                    res.outc = htt_pkg::OC_NUL;
                end
                else
                begin
                    res.role  = htt_pkg::ROLE_VALUE;
                    res.taken = 1'b1;
                end
            end
            default:
            begin
                clear_cnt = 1'b1;
                if (is_lt)
                begin
                    res.taken  = 1'b1;
                    phase_next = htt_pkg::PH_PRE;
                end
                else
                begin
                    res.outc   = htt_pkg::OC_NOT_TAG;
                    phase_next = htt_pkg::PH_IDLE;
                end
            end
        endcase

        // Byte re-examined at the gap between attributes
        if (phase_next == htt_pkg::PH_GAP && !res.taken && res.outc == htt_pkg::OC_BUSY)
        begin
            if (is_nul)
            begin
                res.outc = htt_pkg::OC_NUL;
            end
            else if (is_gt)
            begin
                res.taken = 1'b1;
                res.outc  = htt_pkg::OC_GT;
            end
            else if (is_sp)
            begin
                res.taken = 1'b1;
            end
            else if (is_eq)
            begin
                res.outc = htt_pkg::OC_STRAY_EQ;
            end
            else
            begin
                res.role   = htt_pkg::ROLE_ANAME;
                res.taken  = 1'b1;
                phase_next = htt_pkg::PH_ANAME;
            end
        end

        if (res.outc != htt_pkg::OC_BUSY)
        begin
            phase_next = htt_pkg::PH_IDLE;
        end

        // Saturating byte count, then clamp to the output width
        count_base = clear_cnt ? '0 : count_reg;
        if (res.taken && (count_base != {htt_pkg::LENGTH_BITS{1'b1}}))
        begin
            count_next = count_base + 1'b1;
        end
        else
        begin
            count_next = count_base;
        end
        count_ext      = 32'(count_next);
        res.tag_length = (count_ext > 32'h0000_FFFF) ? {htt_pkg::TAG_LEN_W{1'b1}} :
                         count_ext[htt_pkg::TAG_LEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= htt_pkg::PH_IDLE;
            qsingle_reg <= 1'b0;
            count_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            qsingle_reg <= qsingle_next;
            count_reg   <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/html_tag_head_tokenizer.sv @@
// ----------------------------------------------------------------------------
// html_tag_head_tokenizer
// Tokenizes an HTML tag head one text byte per item, labeling each byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one text byte (data_byte) per
//   item; a zero byte marks end of text. Each input item yields exactly one
//   result item on out_valid/out_ready: role, byte_taken, attr_done,
//   quote_kind, outcome and tag_length.
//   Path: a byte accepted from the input channel lands in the input
//   register; its result is registered in the result register when the
//   byte advances. Throughput is one item per cycle while the receiver
//   does not stall: the whole phase chain for a byte is resolved in the
//   step logic between the input and result registers.
//   If the receiver stalls, the result register holds its item, the input
//   register holds one more byte, and in_ready then drops until out_ready
//   returns. Parse state advances only when a byte moves into the result
//   register.
//   Reset (rst_n low, asynchronous) empties both registers and returns the
//   parser to idle, waiting for '<', with a zero length count.
// ----------------------------------------------------------------------------
`default_nettype none

module html_tag_head_tokenizer (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [7:0]                          data_byte,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [2:0]                               role,
    output logic                                     byte_taken,
    output logic                                     attr_done,
    output logic [1:0]                               quote_kind,
    output logic [2:0]                               outcome,
    output logic [15:0]                              tag_length
);

    logic                              held_valid;
    logic [htt_pkg::BYTE_W-1:0]        held_byte;
    logic                              advance;
    htt_pkg::result_t                  step_res;
    htt_pkg::result_t                  res_reg;
    logic                              out_valid_reg;
    logic                              out_valid_next;

    assign advance = held_valid && (!out_valid_reg || out_ready);

    htt_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    htt_fsm u_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .cur_byte (held_byte),
        .res      (step_res)
    );

    assign out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign role       = res_reg.role;
    assign byte_taken = res_reg.taken;
    assign attr_done  = res_reg.done;
    assign quote_kind = res_reg.qk;
    assign outcome    = res_reg.outc;
    assign tag_length = res_reg.tag_length;

endmodule

`default_nettype wire
